// ----- hdl/depq_pkg.sv -----
// Shared types and codes for the double-ended priority queue.
// No dependencies; used by the channel interfaces, the cell and the top level.
package depq_pkg;

  localparam int VAL_W = 32;
  localparam int OCC_W = 11;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_MAX = 2'd1,
    CMD_DEL_MIN = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_EMPTY_DELETE = 2'd1,
    ST_FULL_INSERT  = 2'd2
  } status_t;

  // Number of values held in one cell.
  typedef enum logic [1:0] {
    FILL_NONE = 2'd0,
    FILL_ONE  = 2'd1,
    FILL_TWO  = 2'd2
  } fill_t;

  // Request travelling down the chain, one cell per cycle.
  typedef struct packed {
    logic valid;
    cmd_t op;
    val_t value;
  } req_t;

  // What a cell shows to the cell above it. With one value, lo == hi.
  typedef struct packed {
    fill_t fill;
    val_t  lo;
    val_t  hi;
  } view_t;

endpackage

// ----- hdl/depq_in_if.sv -----
// Request channel of the double-ended priority queue: valid/ready plus payload.
// Depends on depq_pkg.
interface depq_in_if;
  logic              valid;
  logic              ready;
  depq_pkg::cmd_t    command;
  depq_pkg::val_t    value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

// ----- hdl/depq_out_if.sv -----
// Result channel of the double-ended priority queue: valid/ready plus payload.
// Depends on depq_pkg.
interface depq_out_if;
  logic                          valid;
  logic                          ready;
  depq_pkg::status_t             status;
  logic                          is_empty;
  depq_pkg::val_t                max_value;
  depq_pkg::val_t                min_value;
  logic [depq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output is_empty, output max_value,
                  output min_value, output occupancy, input ready);
  modport sink (input valid, input status, input is_empty, input max_value,
                input min_value, input occupancy, output ready);
endinterface

// ----- hdl/depq_cell.sv -----
// One cell of the queue chain: holds the min and max of everything at and below it.
// Depends on depq_pkg. Instantiated in a row by double_ended_priority_queue.
module depq_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             flush,
  input  depq_pkg::req_t   req_in,
  input  depq_pkg::view_t  below,
  output depq_pkg::view_t  view,
  output depq_pkg::req_t   req_out
);

  depq_pkg::fill_t fill, fill_next;
  depq_pkg::val_t  lo, lo_next;
  depq_pkg::val_t  hi, hi_next;
  depq_pkg::req_t  pass;

  always_comb begin
    fill_next   = fill;
    lo_next     = lo;
    hi_next     = hi;
    pass        = '0;
    pass.op     = req_in.op;
    pass.value  = req_in.value;
    if (req_in.valid) begin
      unique case (req_in.op)
        depq_pkg::CMD_INSERT: begin
          if (fill == depq_pkg::FILL_NONE) begin
            lo_next   = req_in.value;
            hi_next   = req_in.value;
            fill_next = depq_pkg::FILL_ONE;
          end else if (fill == depq_pkg::FILL_ONE) begin
            if (req_in.value < lo) lo_next = req_in.value;
            else hi_next = req_in.value;
            fill_next = depq_pkg::FILL_TWO;
          end else begin
            // full cell: keep the extremes, push the middle value down
            pass.valid = 1'b1;
            if (req_in.value < lo) begin
              lo_next    = req_in.value;
              pass.value = lo;
            end else if (req_in.value > hi) begin
              hi_next    = req_in.value;
              pass.value = hi;
            end
          end
        end
        depq_pkg::CMD_DEL_MAX: begin
          if (fill == depq_pkg::FILL_ONE) begin
            fill_next = depq_pkg::FILL_NONE;
          end else if (below.fill == depq_pkg::FILL_NONE) begin
            hi_next   = lo;
            fill_next = depq_pkg::FILL_ONE;
          end else begin
            hi_next    = below.hi;
            pass.valid = 1'b1;
          end
        end
        depq_pkg::CMD_DEL_MIN: begin
          if (fill == depq_pkg::FILL_ONE) begin
            fill_next = depq_pkg::FILL_NONE;
          end else if (below.fill == depq_pkg::FILL_NONE) begin
            lo_next   = hi;
            fill_next = depq_pkg::FILL_ONE;
          end else begin
            lo_next    = below.lo;
            pass.valid = 1'b1;
          end
        end
        default: begin
          // clear is handled by flush
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      fill          <= depq_pkg::FILL_NONE;
      req_out.valid <= 1'b0;
    end else begin
      fill          <= fill_next;
      req_out.valid <= pass.valid;
    end
    lo            <= lo_next;
    hi            <= hi_next;
    req_out.op    <= pass.op;
    req_out.value <= pass.value;
  end

  assign view.fill = fill;
  assign view.lo   = lo;
  assign view.hi   = hi;

endmodule

// ----- hdl/double_ended_priority_queue.sv -----
// Double-ended priority queue of signed 32-bit values, duplicates allowed.
// Top level; depends on depq_pkg, depq_in_if, depq_out_if and depq_cell.
//
// Usage:
//   cmd (sink): command (insert, delete max, delete min, clear) and value.
//   rsp (source): status, is_empty, max_value, min_value, occupancy, one per request.
//   An accepted request is registered in stage1, then held in cap, until its result
//   is registered on rsp. No new request is taken while stage1 is set: a request
//   walks down a row of (CAPACITY+1)/2 cells one cell per cycle, and each cell must
//   settle before the next request reaches it. Clear takes effect on all cells at once.
//   A delete on an empty queue reports status 1 and changes nothing; an insert
//   into a full queue reports status 2 and is dropped.
//   Reset empties the queue at once; stored values need no clearing.
//   If rsp stalls, one result waits in the output register, one more may wait
//   behind it, and cmd.ready drops until the output moves again.
module double_ended_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input logic       clk,
  input logic       rst,
  depq_in_if.sink   cmd,
  depq_out_if.source rsp
);

  localparam int NCELL = (CAPACITY + 1) / 2;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count;
  logic               stage1;
  logic               cap;
  logic               flush_q;
  depq_pkg::status_t  pstat;
  depq_pkg::req_t     head_req;
  depq_pkg::req_t     reqs  [NCELL+1];
  depq_pkg::view_t    views [NCELL+1];

  logic accept;
  logic is_full;
  logic no_vals;
  logic out_free;
  logic take_effect;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign no_vals  = (count == '0);
  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = !stage1 && (!cap || out_free);

  always_comb begin
    unique case (cmd.command)
      depq_pkg::CMD_INSERT:  take_effect = !is_full;
      depq_pkg::CMD_DEL_MAX,
      depq_pkg::CMD_DEL_MIN: take_effect = !no_vals;
      default:               take_effect = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      stage1       <= 1'b0;
      cap          <= 1'b0;
      flush_q      <= 1'b0;
      head_req.valid <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      stage1        <= accept;
      flush_q       <= accept && (cmd.command == depq_pkg::CMD_CLEAR);
      head_req.valid <= accept && take_effect;
      if (accept) begin
        unique case (cmd.command)
          depq_pkg::CMD_INSERT:  if (!is_full) count <= count + CNT_W'(1);
          depq_pkg::CMD_DEL_MAX,
          depq_pkg::CMD_DEL_MIN: if (!no_vals) count <= count - CNT_W'(1);
          default:               count <= '0;
        endcase
      end
      if (stage1) cap <= 1'b1;
      else if (cap && out_free) cap <= 1'b0;
      if (cap && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
    if (accept) begin
      head_req.op    <= cmd.command;
      head_req.value <= cmd.value;
      if (cmd.command == depq_pkg::CMD_INSERT && is_full) pstat <= depq_pkg::ST_FULL_INSERT;
      else if ((cmd.command == depq_pkg::CMD_DEL_MAX || cmd.command == depq_pkg::CMD_DEL_MIN)
               && no_vals) pstat <= depq_pkg::ST_EMPTY_DELETE;
      else pstat <= depq_pkg::ST_DONE;
    end
    if (cap && out_free) begin
      rsp.status    <= pstat;
      rsp.is_empty  <= no_vals;
      rsp.max_value <= no_vals ? '0 : views[0].hi;
      rsp.min_value <= no_vals ? '0 : views[0].lo;
      rsp.occupancy <= depq_pkg::OCC_W'(count);
    end
  end

  assign reqs[0] = head_req;

  // nothing lives past the last cell
  assign views[NCELL] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    depq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .flush   (flush_q),
      .req_in  (reqs[k]),
      .below   (views[k+1]),
      .view    (views[k]),
      .req_out (reqs[k+1])
    );
  end

`ifndef ASSERT_OFF
  // once the chain head is quiet, its fill agrees with the global count
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (!reqs[0].valid && !flush_q) |-> ((count == '0) == (views[0].fill == depq_pkg::FILL_NONE)))
    else $error("cell 0 fill disagrees with count");

  // the guard on full inserts must keep requests from falling off the chain
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !reqs[NCELL].valid)
    else $error("request passed beyond the last cell");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == depq_pkg::CMD_INSERT && !is_full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not bump count");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (views[0].fill == depq_pkg::FILL_TWO && !reqs[0].valid) |-> (views[0].lo <= views[0].hi))
    else $error("cell 0 min above max");
`endif

endmodule
